### rtl/bcf_pkg.sv
package bcf_pkg;

  typedef enum logic [1:0] {
    KIND_INC      = 2'd0,
    KIND_LEFT     = 2'd1,
    KIND_VALIDATE = 2'd2,
    KIND_WRITE    = 2'd3
  } kind_t;

  // cursor positions
  localparam logic [3:0] POS_YEAR    = 4'd0;
  localparam logic [3:0] POS_MONTH   = 4'd1;
  localparam logic [3:0] POS_DATE    = 4'd2;
  localparam logic [3:0] POS_WEEKDAY = 4'd3;
  localparam logic [3:0] POS_HOUR    = 4'd4;
  localparam logic [3:0] POS_MINUTE  = 4'd5;
  localparam logic [3:0] POS_SECOND  = 4'd6;
  localparam logic [3:0] POS_AMPM    = 4'd7;
  localparam logic [3:0] POS_IDLE    = 4'd8;

  // register map
  localparam logic [2:0] REG_SECOND  = 3'd0;
  localparam logic [2:0] REG_MINUTE  = 3'd1;
  localparam logic [2:0] REG_HOUR    = 3'd2;
  localparam logic [2:0] REG_WEEKDAY = 3'd3;
  localparam logic [2:0] REG_DATE    = 3'd4;
  localparam logic [2:0] REG_MONTH   = 3'd5;
  localparam logic [2:0] REG_YEAR    = 3'd6;
  localparam logic [2:0] REG_CONTROL = 3'd7;

  // default time: 2007-06-01 fri 12:00:00 am, 12-hour mode
  localparam logic [7:0] DEF_SECOND  = 8'h00;
  localparam logic [7:0] DEF_MINUTE  = 8'h00;
  localparam logic [7:0] DEF_HOUR    = 8'h52;
  localparam logic [7:0] DEF_WEEKDAY = 8'h06;
  localparam logic [7:0] DEF_DATE    = 8'h01;
  localparam logic [7:0] DEF_MONTH   = 8'h06;
  localparam logic [7:0] DEF_YEAR    = 8'h07;
  localparam logic [7:0] DEF_CONTROL = 8'h00;

  typedef logic [7:0] bcd_byte_t;
  typedef bcd_byte_t [7:0] regfile_t;

  typedef struct packed {
    logic [7:0] year;
    logic [7:0] month;
    logic [7:0] date;
    logic [7:0] weekday;
    logic [5:0] hour;
    logic       pm;
    logic [7:0] minute;
    logic [7:0] second;
    logic       beep;
  } disp_t;

  // decimal value of both nibbles plus one, re-encoded as two bcd digits
  function automatic logic [7:0] bcd_inc(input logic [7:0] b);
    logic [7:0]  v;
    logic [15:0] prod;
    logic [4:0]  q;
    logic [7:0]  r;
    v    = 8'({4'b0, b[7:4]} * 8'd10) + {4'b0, b[3:0]} + 8'd1;
    // divide by ten via reciprocal, exact for v below 256
    prod = {8'b0, v} * 16'd205;
    q    = prod[15:11];
    r    = v - 8'({3'b0, q} * 8'd10);
    return {q[3:0], 4'b0} + r;
  endfunction

endpackage

### rtl/bcf_update.sv
module bcf_update (
  input  bcf_pkg::kind_t    kind,
  input  logic [2:0]        reg_address,
  input  logic [7:0]        reg_value,
  input  logic [3:0]        cursor,
  input  bcf_pkg::regfile_t regs,
  output logic [3:0]        new_cursor,
  output bcf_pkg::regfile_t new_regs,
  output logic              reinit
);

  logic [7:0] sec, min, hr, wday, date, mon, yr;
  logic [5:0] h6;
  logic [7:0] hr_inc;
  logic       bad;

  assign sec  = regs[bcf_pkg::REG_SECOND];
  assign min  = regs[bcf_pkg::REG_MINUTE];
  assign hr   = regs[bcf_pkg::REG_HOUR];
  assign wday = regs[bcf_pkg::REG_WEEKDAY];
  assign date = regs[bcf_pkg::REG_DATE];
  assign mon  = regs[bcf_pkg::REG_MONTH];
  assign yr   = regs[bcf_pkg::REG_YEAR];
  assign h6   = hr[5:0];

  // 12 -> 1, pm 12 -> pm 1, else bcd step; 12-hour bit always set
  always_comb begin
    if (h6 == 6'h12) begin
      hr_inc = 8'h01 | 8'h40;
    end else if (h6 == 6'h32) begin
      hr_inc = 8'h21 | 8'h40;
    end else begin
      hr_inc = bcf_pkg::bcd_inc({2'b0, h6}) | 8'h40;
    end
  end

  assign bad = (sec == 8'h00) || (sec > 8'h59) ||
               (min == 8'h00) || (min > 8'h59) ||
               ((hr & 8'h9F) == 8'h00) || ((hr & 8'h40) == 8'h00) ||
               ((hr & 8'h9F) > 8'h12) ||
               (wday == 8'h00) || (wday > 8'h07) ||
               (date == 8'h00) || (date > 8'h31) ||
               (mon == 8'h00) || (mon > 8'h12) ||
               (yr > 8'h99);

  always_comb begin
    new_cursor = cursor;
    new_regs   = regs;
    reinit     = 1'b0;
    case (kind)
      bcf_pkg::KIND_INC: begin
        case (cursor)
          bcf_pkg::POS_YEAR:
            new_regs[bcf_pkg::REG_YEAR] = (yr == 8'h99) ? 8'h00 : bcf_pkg::bcd_inc(yr);
          bcf_pkg::POS_MONTH:
            new_regs[bcf_pkg::REG_MONTH] = (mon == 8'h12) ? 8'h01 : bcf_pkg::bcd_inc(mon);
          bcf_pkg::POS_DATE:
            new_regs[bcf_pkg::REG_DATE] = (date == 8'h31) ? 8'h01 : bcf_pkg::bcd_inc(date);
          bcf_pkg::POS_WEEKDAY:
            new_regs[bcf_pkg::REG_WEEKDAY] = (wday == 8'h07) ? 8'h01 : wday + 8'd1;
          bcf_pkg::POS_HOUR:
            new_regs[bcf_pkg::REG_HOUR] = hr_inc;
          bcf_pkg::POS_MINUTE:
            new_regs[bcf_pkg::REG_MINUTE] = (min == 8'h59) ? 8'h00 : bcf_pkg::bcd_inc(min);
          bcf_pkg::POS_SECOND:
            new_regs[bcf_pkg::REG_SECOND] = (sec == 8'h59) ? 8'h00 : bcf_pkg::bcd_inc(sec);
          bcf_pkg::POS_AMPM:
            new_regs[bcf_pkg::REG_HOUR] = hr ^ 8'h20;
          default: ;
        endcase
      end
      bcf_pkg::KIND_LEFT: begin
        if (cursor == bcf_pkg::POS_YEAR) begin
          new_cursor = bcf_pkg::POS_IDLE;
        end else if (cursor <= bcf_pkg::POS_IDLE) begin
          new_cursor = cursor - 4'd1;
        end
      end
      bcf_pkg::KIND_VALIDATE: begin
        if (bad) begin
          new_regs[bcf_pkg::REG_SECOND]  = bcf_pkg::DEF_SECOND;
          new_regs[bcf_pkg::REG_MINUTE]  = bcf_pkg::DEF_MINUTE;
          new_regs[bcf_pkg::REG_HOUR]    = bcf_pkg::DEF_HOUR;
          new_regs[bcf_pkg::REG_WEEKDAY] = bcf_pkg::DEF_WEEKDAY;
          new_regs[bcf_pkg::REG_DATE]    = bcf_pkg::DEF_DATE;
          new_regs[bcf_pkg::REG_MONTH]   = bcf_pkg::DEF_MONTH;
          new_regs[bcf_pkg::REG_YEAR]    = bcf_pkg::DEF_YEAR;
          new_regs[bcf_pkg::REG_CONTROL] = bcf_pkg::DEF_CONTROL;
          reinit = 1'b1;
        end
      end
      bcf_pkg::KIND_WRITE: begin
        new_regs[reg_address] = reg_value;
      end
      default: ;
    endcase
  end

endmodule

### rtl/bcf_display.sv
module bcf_display (
  input  bcf_pkg::regfile_t regs,
  output bcf_pkg::disp_t    disp
);

  logic [5:0] h;
  logic       pm;

  assign h  = regs[bcf_pkg::REG_HOUR][5:0];
  assign pm = (h > 6'h20);

  always_comb begin
    disp.year    = regs[bcf_pkg::REG_YEAR];
    disp.month   = regs[bcf_pkg::REG_MONTH];
    disp.date    = regs[bcf_pkg::REG_DATE];
    disp.weekday = regs[bcf_pkg::REG_WEEKDAY];
    disp.hour    = pm ? (h & 6'h1F) : h;
    disp.pm      = pm;
    disp.minute  = regs[bcf_pkg::REG_MINUTE];
    disp.second  = regs[bcf_pkg::REG_SECOND];
    disp.beep    = (regs[bcf_pkg::REG_MINUTE] == 8'h00) &&
                   (regs[bcf_pkg::REG_SECOND] == 8'h00);
  end

endmodule

### rtl/bcd_clock_field_editor.sv
// path: the transfer edge loads the input register; the result register
//   loads the item's result once it is free, and out_valid then rises
// throughput: one item per cycle unless out_stall holds; the clock store
//   and cursor update in one pass of logic from input to result register
// reset (rst_n low, synchronous): store cleared to zero, cursor idle, both
//   stages empty
module bcd_clock_field_editor (
  input  logic       clk,
  input  logic       rst_n,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_kind,
  input  logic [2:0] in_reg_address,
  input  logic [7:0] in_reg_value,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [3:0] out_cursor_field,
  output logic [7:0] out_year_bcd,
  output logic [7:0] out_month_bcd,
  output logic [7:0] out_date_bcd,
  output logic [7:0] out_weekday_num,
  output logic [5:0] out_hour_bcd,
  output logic       out_pm_flag,
  output logic [7:0] out_minute_bcd,
  output logic [7:0] out_second_bcd,
  output logic       out_hourly_beep,
  output logic       out_reinitialized
);

  // input register
  logic           s1_valid_r;
  bcf_pkg::kind_t s1_kind_r;
  logic [2:0]     s1_addr_r;
  logic [7:0]     s1_value_r;

  // architectural state
  logic [3:0]        cursor_r, cursor_nxt;
  bcf_pkg::regfile_t regs_r, regs_nxt;
  logic              reinit_nxt;
  bcf_pkg::disp_t    disp_nxt;

  // result register
  logic           out_valid_r;
  logic [3:0]     out_cursor_r;
  bcf_pkg::disp_t out_disp_r;
  logic           out_reinit_r;

  logic out_free;   // result register can take a new result this cycle
  logic s1_fire;    // item in the input register is applied to the store
  logic in_xfer;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  // input register is free when empty or draining this cycle
  assign in_stall = s1_valid_r && !out_free;
  assign in_xfer  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_r <= 1'b1;
    end else if (s1_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_kind_r  <= bcf_pkg::kind_t'(in_kind);
      s1_addr_r  <= in_reg_address;
      s1_value_r <= in_reg_value;
    end
  end

  // next store, cursor and reload flag for the item in the input register
  bcf_update u_update (
    .kind        (s1_kind_r),
    .reg_address (s1_addr_r),
    .reg_value   (s1_value_r),
    .cursor      (cursor_r),
    .regs        (regs_r),
    .new_cursor  (cursor_nxt),
    .new_regs    (regs_nxt),
    .reinit      (reinit_nxt)
  );

  // display decode of the updated store
  bcf_display u_display (
    .regs (regs_nxt),
    .disp (disp_nxt)
  );

  // control state: reset zeroes the clock store and idles the cursor
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cursor_r <= bcf_pkg::POS_IDLE;
      regs_r   <= '0;
    end else if (s1_fire) begin
      cursor_r <= cursor_nxt;
      regs_r   <= regs_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_cursor_r <= cursor_nxt;
      out_disp_r   <= disp_nxt;
      out_reinit_r <= reinit_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_cursor_field  = out_cursor_r;
  assign out_year_bcd      = out_disp_r.year;
  assign out_month_bcd     = out_disp_r.month;
  assign out_date_bcd      = out_disp_r.date;
  assign out_weekday_num   = out_disp_r.weekday;
  assign out_hour_bcd      = out_disp_r.hour;
  assign out_pm_flag       = out_disp_r.pm;
  assign out_minute_bcd    = out_disp_r.minute;
  assign out_second_bcd    = out_disp_r.second;
  assign out_hourly_beep   = out_disp_r.beep;
  assign out_reinitialized = out_reinit_r;

  // cursor stays within the ring of nine positions
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    cursor_r <= bcf_pkg::POS_IDLE)
    else $error("cursor left its ring");

  // a reload result shows the default date
  a_reload_default: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_reinit_r |->
      out_disp_r.year == bcf_pkg::DEF_YEAR && out_disp_r.month == bcf_pkg::DEF_MONTH &&
      out_disp_r.date == bcf_pkg::DEF_DATE && out_disp_r.weekday == bcf_pkg::DEF_WEEKDAY)
    else $error("reload result does not show default date");

  // a register write lands in the store
  a_write_lands: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && s1_kind_r == bcf_pkg::KIND_WRITE |=>
      regs_r[$past(s1_addr_r)] == $past(s1_value_r))
    else $error("register write lost");

  // an applied item always produces a result on the next edge
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("applied item produced no result");

endmodule

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int WATCHDOG_LIMIT = 2000;   // cycles with no transfer on either side
  localparam int RANDOM_ITEMS   = 1100;
  localparam int LONG_HOLD      = 250;    // receiver hold-off that fills the pipe
  localparam int DRAIN_POINT    = 500;    // sender pauses here until all results are in

  // expected view of one result: cursor, decoded display, reload flag
  typedef struct packed {
    logic [3:0]     cursor;
    bcf_pkg::disp_t shown;
    logic           reinit;
  } clock_view_t;

  // predicts the display after each input transfer and checks results in order
  class display_scoreboard;
    clock_view_t        expected_views[$];
    logic [3:0]         cursor;
    bcf_pkg::bcd_byte_t regs [8];
    int                 errors;
    int                 results_checked;

    function new();
      cursor = bcf_pkg::POS_IDLE;
      foreach (regs[i]) regs[i] = 8'h00;
      errors = 0;
      results_checked = 0;
    endfunction

    // two-digit decimal value plus one, re-encoded, low 8 bits kept
    function bcf_pkg::bcd_byte_t bcd_plus_one(bcf_pkg::bcd_byte_t b);
      int v;
      v = int'(b[7:4]) * 10 + int'(b[3:0]) + 1;
      return bcf_pkg::bcd_byte_t'(((v / 10) << 4) + (v % 10));
    endfunction

    function bcf_pkg::bcd_byte_t bcd_wrap(bcf_pkg::bcd_byte_t b, bcf_pkg::bcd_byte_t top,
                                          bcf_pkg::bcd_byte_t first);
      return (b == top) ? first : bcd_plus_one(b);
    endfunction

    function bit store_out_of_range();
      bcf_pkg::bcd_byte_t sec, mins, hr, wday, dt, mon, yr;
      sec  = regs[bcf_pkg::REG_SECOND];
      mins = regs[bcf_pkg::REG_MINUTE];
      hr   = regs[bcf_pkg::REG_HOUR];
      wday = regs[bcf_pkg::REG_WEEKDAY];
      dt   = regs[bcf_pkg::REG_DATE];
      mon  = regs[bcf_pkg::REG_MONTH];
      yr   = regs[bcf_pkg::REG_YEAR];
      if (sec == 8'h00 || sec > 8'h59) return 1'b1;
      if (mins == 8'h00 || mins > 8'h59) return 1'b1;
      if ((hr & 8'h9F) == 8'h00) return 1'b1;
      if ((hr & 8'h40) == 8'h00) return 1'b1;
      if ((hr & 8'h9F) > 8'h12) return 1'b1;
      if (wday == 8'h00 || wday > 8'h07) return 1'b1;
      if (dt == 8'h00 || dt > 8'h31) return 1'b1;
      if (mon == 8'h00 || mon > 8'h12) return 1'b1;
      if (yr > 8'h99) return 1'b1;
      return 1'b0;
    endfunction

    function void bump_field_at_cursor();
      bcf_pkg::bcd_byte_t h;
      case (cursor)
        bcf_pkg::POS_YEAR:
          regs[bcf_pkg::REG_YEAR] = bcd_wrap(regs[bcf_pkg::REG_YEAR], 8'h99, 8'h00);
        bcf_pkg::POS_MONTH:
          regs[bcf_pkg::REG_MONTH] = bcd_wrap(regs[bcf_pkg::REG_MONTH], 8'h12, 8'h01);
        bcf_pkg::POS_DATE:
          regs[bcf_pkg::REG_DATE] = bcd_wrap(regs[bcf_pkg::REG_DATE], 8'h31, 8'h01);
        bcf_pkg::POS_WEEKDAY: begin
          if (regs[bcf_pkg::REG_WEEKDAY] == 8'h07) regs[bcf_pkg::REG_WEEKDAY] = 8'h01;
          else regs[bcf_pkg::REG_WEEKDAY] = regs[bcf_pkg::REG_WEEKDAY] + 8'h01;
        end
        bcf_pkg::POS_HOUR: begin
          h = regs[bcf_pkg::REG_HOUR] & 8'h3F;
          if (h == 8'h12) h = 8'h01;
          else if (h == 8'h32) h = 8'h21;
          else h = bcd_plus_one(h);
          regs[bcf_pkg::REG_HOUR] = h | 8'h40;
        end
        bcf_pkg::POS_MINUTE:
          regs[bcf_pkg::REG_MINUTE] = bcd_wrap(regs[bcf_pkg::REG_MINUTE], 8'h59, 8'h00);
        bcf_pkg::POS_SECOND:
          regs[bcf_pkg::REG_SECOND] = bcd_wrap(regs[bcf_pkg::REG_SECOND], 8'h59, 8'h00);
        bcf_pkg::POS_AMPM:
          regs[bcf_pkg::REG_HOUR] = regs[bcf_pkg::REG_HOUR] ^ 8'h20;
        default: ;
      endcase
    endfunction

    // advance the store by one accepted item and queue the display it causes
    function void note_transfer(bcf_pkg::kind_t k, logic [2:0] addr, bcf_pkg::bcd_byte_t val);
      clock_view_t        view;
      bcf_pkg::bcd_byte_t h;
      view.reinit = 1'b0;
      case (k)
        bcf_pkg::KIND_INC:  bump_field_at_cursor();
        bcf_pkg::KIND_LEFT: begin
          if (cursor == bcf_pkg::POS_YEAR) cursor = bcf_pkg::POS_IDLE;
          else if (cursor <= bcf_pkg::POS_IDLE) cursor = cursor - 4'd1;
        end
        bcf_pkg::KIND_VALIDATE: begin
          if (store_out_of_range()) begin
            regs[bcf_pkg::REG_SECOND]  = bcf_pkg::DEF_SECOND;
            regs[bcf_pkg::REG_MINUTE]  = bcf_pkg::DEF_MINUTE;
            regs[bcf_pkg::REG_HOUR]    = bcf_pkg::DEF_HOUR;
            regs[bcf_pkg::REG_WEEKDAY] = bcf_pkg::DEF_WEEKDAY;
            regs[bcf_pkg::REG_DATE]    = bcf_pkg::DEF_DATE;
            regs[bcf_pkg::REG_MONTH]   = bcf_pkg::DEF_MONTH;
            regs[bcf_pkg::REG_YEAR]    = bcf_pkg::DEF_YEAR;
            regs[bcf_pkg::REG_CONTROL] = bcf_pkg::DEF_CONTROL;
            view.reinit = 1'b1;
          end
        end
        default: regs[addr] = val;
      endcase
      h = regs[bcf_pkg::REG_HOUR] & 8'h3F;
      view.shown.pm = (h > 8'h20);
      if (view.shown.pm) h = h & 8'h1F;
      view.cursor        = cursor;
      view.shown.year    = regs[bcf_pkg::REG_YEAR];
      view.shown.month   = regs[bcf_pkg::REG_MONTH];
      view.shown.date    = regs[bcf_pkg::REG_DATE];
      view.shown.weekday = regs[bcf_pkg::REG_WEEKDAY];
      view.shown.hour    = h[5:0];
      view.shown.minute  = regs[bcf_pkg::REG_MINUTE];
      view.shown.second  = regs[bcf_pkg::REG_SECOND];
      view.shown.beep    = (regs[bcf_pkg::REG_MINUTE] == 8'h00 &&
                            regs[bcf_pkg::REG_SECOND] == 8'h00);
      expected_views.push_back(view);
    endfunction

    function void check_view(clock_view_t got);
      clock_view_t want;
      results_checked++;
      if (expected_views.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result with nothing expected: %h", got);
        return;
      end
      want = expected_views.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10) begin
          $display("mismatch (expected/actual): cursor %h/%h year %h/%h month %h/%h",
                   want.cursor, got.cursor, want.shown.year, got.shown.year,
                   want.shown.month, got.shown.month);
          $display("  date %h/%h weekday %h/%h hour %h/%h pm %b/%b minute %h/%h",
                   want.shown.date, got.shown.date, want.shown.weekday, got.shown.weekday,
                   want.shown.hour, got.shown.hour, want.shown.pm, got.shown.pm,
                   want.shown.minute, got.shown.minute);
          $display("  second %h/%h beep %b/%b reinit %b/%b",
                   want.shown.second, got.shown.second, want.shown.beep, got.shown.beep,
                   want.reinit, got.reinit);
        end
      end
    endfunction
  endclass

  display_scoreboard sb = new();

  // clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;
  always #5 clk = ~clk;

  // block ports; the inputs are known from time zero
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [1:0] in_kind        = bcf_pkg::KIND_INC;
  logic [2:0] in_reg_address = 3'd0;
  logic [7:0] in_reg_value   = 8'h00;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [3:0] out_cursor_field;
  logic [7:0] out_year_bcd;
  logic [7:0] out_month_bcd;
  logic [7:0] out_date_bcd;
  logic [7:0] out_weekday_num;
  logic [5:0] out_hour_bcd;
  logic       out_pm_flag;
  logic [7:0] out_minute_bcd;
  logic [7:0] out_second_bcd;
  logic       out_hourly_beep;
  logic       out_reinitialized;

  bcd_clock_field_editor uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_kind           (in_kind),
    .in_reg_address    (in_reg_address),
    .in_reg_value      (in_reg_value),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_cursor_field  (out_cursor_field),
    .out_year_bcd      (out_year_bcd),
    .out_month_bcd     (out_month_bcd),
    .out_date_bcd      (out_date_bcd),
    .out_weekday_num   (out_weekday_num),
    .out_hour_bcd      (out_hour_bcd),
    .out_pm_flag       (out_pm_flag),
    .out_minute_bcd    (out_minute_bcd),
    .out_second_bcd    (out_second_bcd),
    .out_hourly_beep   (out_hourly_beep),
    .out_reinitialized (out_reinitialized)
  );

  int items_sent = 0;
  int burst_left = 0;

  // mostly short bursts, now and then a long one with no idling at all
  function automatic int pick_burst();
    if ($urandom_range(0, 4) == 0) return $urandom_range(40, 120);
    return $urandom_range(1, 10);
  endfunction

  // offer one item and hold it until the transfer; gaps fall between bursts
  task automatic send_item(input bcf_pkg::kind_t k, input logic [2:0] addr,
                           input logic [7:0] val);
    in_valid       <= 1'b1;
    in_kind        <= k;
    in_reg_address <= addr;
    in_reg_value   <= val;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_transfer(k, addr, val);
    items_sent++;
    burst_left--;
    if (burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = pick_burst();
    end
  endtask

  // non-write items carry random address and value that the block must ignore
  task automatic send_op(input bcf_pkg::kind_t k);
    send_item(k, 3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(input logic [2:0] addr, input logic [7:0] val);
    send_item(bcf_pkg::KIND_WRITE, addr, val);
  endtask

  // stop offering until every expected result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_views.size() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] to_bcd(int d);
    return 8'(((d / 10) << 4) | (d % 10));
  endfunction

  // a plausible register value, with a raw byte now and then
  function automatic logic [7:0] field_value(logic [2:0] addr);
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, 255));
    case (addr)
      bcf_pkg::REG_SECOND, bcf_pkg::REG_MINUTE: return to_bcd($urandom_range(0, 59));
      bcf_pkg::REG_HOUR: begin
        return 8'h40 | ($urandom_range(0, 1) ? 8'h20 : 8'h00) | to_bcd($urandom_range(1, 12));
      end
      bcf_pkg::REG_WEEKDAY: return to_bcd($urandom_range(1, 7));
      bcf_pkg::REG_DATE:    return to_bcd($urandom_range(1, 31));
      bcf_pkg::REG_MONTH:   return to_bcd($urandom_range(1, 12));
      bcf_pkg::REG_YEAR:    return to_bcd($urandom_range(0, 99));
      default:              return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // full time set followed by a validate, the normal use of the block
  task automatic set_time_then_validate();
    for (int a = bcf_pkg::REG_SECOND; a <= bcf_pkg::REG_YEAR; a++) begin
      write_reg(3'(a), field_value(3'(a)));
    end
    if ($urandom_range(0, 3) == 0) write_reg(bcf_pkg::REG_CONTROL, 8'($urandom_range(0, 255)));
    send_op(bcf_pkg::KIND_VALIDATE);
  endtask

  // key presses: move the cursor and bump fields, sometimes revalidate
  task automatic edit_fields();
    int n;
    int r;
    n = $urandom_range(1, 12);
    repeat (n) begin
      r = $urandom_range(0, 9);
      if (r < 3) send_op(bcf_pkg::KIND_LEFT);
      else if (r < 9) send_op(bcf_pkg::KIND_INC);
      else send_op(bcf_pkg::KIND_VALIDATE);
    end
  endtask

  task automatic directed_items();
    // validate on a cleared store, then on the defaults (second zero reloads again)
    send_op(bcf_pkg::KIND_VALIDATE);
    send_op(bcf_pkg::KIND_VALIDATE);
    write_reg(bcf_pkg::REG_SECOND, 8'h59);
    write_reg(bcf_pkg::REG_MINUTE, 8'h59);
    send_op(bcf_pkg::KIND_VALIDATE);          // now in range, no reload
    // walk the cursor from idle down the ring, exercising each wrap
    send_op(bcf_pkg::KIND_LEFT);              // ampm
    send_op(bcf_pkg::KIND_INC);               // pm toggle, hour register becomes 0x72 with pm
    send_op(bcf_pkg::KIND_LEFT);              // second
    send_op(bcf_pkg::KIND_INC);               // 59 wraps to 00
    send_op(bcf_pkg::KIND_LEFT);              // minute
    send_op(bcf_pkg::KIND_INC);               // 59 wraps to 00, on-the-hour beep
    send_op(bcf_pkg::KIND_LEFT);              // hour
    send_op(bcf_pkg::KIND_INC);               // 12 pm goes to 01 pm
    write_reg(bcf_pkg::REG_HOUR, 8'h52);
    send_op(bcf_pkg::KIND_INC);               // 12 am goes to 01 am
    write_reg(bcf_pkg::REG_HOUR, 8'hBF);
    send_op(bcf_pkg::KIND_INC);               // non-bcd hour, bit 7 dropped
    send_op(bcf_pkg::KIND_LEFT);              // weekday
    write_reg(bcf_pkg::REG_WEEKDAY, 8'h07);
    send_op(bcf_pkg::KIND_INC);
    write_reg(bcf_pkg::REG_WEEKDAY, 8'hFF);
    send_op(bcf_pkg::KIND_INC);               // plain binary wrap to zero
    send_op(bcf_pkg::KIND_LEFT);              // date
    write_reg(bcf_pkg::REG_DATE, 8'h31);
    send_op(bcf_pkg::KIND_INC);
    send_op(bcf_pkg::KIND_LEFT);              // month
    write_reg(bcf_pkg::REG_MONTH, 8'h12);
    send_op(bcf_pkg::KIND_INC);
    send_op(bcf_pkg::KIND_LEFT);              // year
    write_reg(bcf_pkg::REG_YEAR, 8'h99);
    send_op(bcf_pkg::KIND_INC);
    send_op(bcf_pkg::KIND_LEFT);              // year wraps round to idle
    send_op(bcf_pkg::KIND_INC);               // idle, nothing changes
    write_reg(bcf_pkg::REG_CONTROL, 8'hFF);
  endtask

  // main stimulus
  initial begin : stimulus
    int r;
    int n;
    bit drained;
    drained = 1'b0;
    burst_left = pick_burst();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    directed_items();
    drain_results();
    while (items_sent < RANDOM_ITEMS) begin
      r = $urandom_range(0, 9);
      if (r < 4) set_time_then_validate();
      else if (r < 8) edit_fields();
      else begin
        // noise: any kind, address and value
        n = $urandom_range(1, 6);
        repeat (n) send_item(bcf_pkg::kind_t'($urandom_range(0, 3)),
                             3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)));
      end
      if (!drained && items_sent >= DRAIN_POINT) begin
        drained = 1'b1;
        drain_results();
      end
    end
    drain_results();
    // then wait on to catch any stray result
    repeat (4) @(posedge clk);
    if (sb.errors == 0 && sb.expected_views.size() == 0) begin
      $display("bcd_clock_field_editor test passed");
    end else begin
      $display("bcd_clock_field_editor test failed");
    end
    $finish;
  end

  // receiver: stall segments of varying density, plus one long hold-off
  initial begin : receiver
    int  mode;
    int  seg_len;
    int  held;
    bit  long_hold_done;
    long_hold_done = 1'b0;
    @(posedge clk);
    forever begin
      if (!long_hold_done && sb.results_checked >= 150) begin
        long_hold_done = 1'b1;
        held = 0;
        while (held < LONG_HOLD) begin
          out_stall <= 1'b1;
          @(posedge clk);
          held++;
        end
      end else begin
        mode    = $urandom_range(0, 3);
        seg_len = $urandom_range(5, 60);
        repeat (seg_len) begin
          case (mode)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 3) == 0);
            2:       out_stall <= ($urandom_range(0, 1) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 8);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  // result monitor: sampled at the edge, before the block updates its outputs
  always @(posedge clk) begin : result_monitor
    clock_view_t got;
    if (rst_n && out_valid && !out_stall) begin
      got.cursor        = out_cursor_field;
      got.shown.year    = out_year_bcd;
      got.shown.month   = out_month_bcd;
      got.shown.date    = out_date_bcd;
      got.shown.weekday = out_weekday_num;
      got.shown.hour    = out_hour_bcd;
      got.shown.pm      = out_pm_flag;
      got.shown.minute  = out_minute_bcd;
      got.shown.second  = out_second_bcd;
      got.shown.beep    = out_hourly_beep;
      got.reinit        = out_reinitialized;
      sb.check_view(got);
    end
  end

  // watchdog: ends the run when no transfer happens for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("bcd_clock_field_editor test failed");
    $finish;
  end

endmodule
